### hw/rtl/ohpl_pkg.sv
// Shared types, constants and elaboration-time helpers for the path loss unit.
// Depends on nothing; every other file of the unit imports it.
package ohpl_pkg;

    localparam int Q_W    = 32;   // Q16 working values
    localparam int P_W    = 56;   // raw products of two Q16 values
    localparam int L_W    = 21;   // widest logarithm operand (1175 * mobile height)
    localparam int LOUT_W = 20;   // log10 result, Q16, never negative

    typedef logic signed [Q_W-1:0] t_q16;
    typedef logic signed [P_W-1:0] t_prod;

    localparam logic [2:0] MODEL_SHORT = 3'd0;
    localparam logic [2:0] MODEL_HATA  = 3'd1;
    localparam logic [2:0] MODEL_COST  = 3'd2;
    localparam logic [2:0] MODEL_EMP   = 3'd3;
    localparam logic [2:0] MODEL_OOB   = 3'd4;

    localparam logic [1:0] CFG_CARRIER    = 2'd0;
    localparam logic [1:0] CFG_LARGE_CITY = 2'd1;
    localparam logic [1:0] CFG_AREA       = 2'd2;
    localparam logic [1:0] CFG_MIN_DIST   = 2'd3;

    localparam logic [1:0] AREA_SUBURBAN = 2'd1;
    localparam logic [1:0] AREA_OPEN     = 2'd2;

    localparam t_q16 ONE_Q16  = 32'sd65536;
    localparam t_q16 K69_55   = 32'sd4558029;
    localparam t_q16 K26_16   = 32'sd1714422;
    localparam t_q16 K13_82   = 32'sd905708;
    localparam t_q16 K44_9    = 32'sd2942566;
    localparam t_q16 K6_55    = 32'sd429261;
    localparam t_q16 K46_3    = 32'sd3034317;
    localparam t_q16 K33_9    = 32'sd2221670;
    localparam t_q16 K8_29    = 32'sd543293;
    localparam t_q16 K1_1     = 32'sd72090;
    localparam t_q16 K3_2     = 32'sd209715;
    localparam t_q16 K4_97    = 32'sd325714;
    localparam t_q16 K0_7     = 32'sd45875;
    localparam t_q16 K1_56    = 32'sd102236;
    localparam t_q16 K0_8     = 32'sd52429;
    localparam t_q16 K5_4     = 32'sd353894;
    localparam t_q16 K4_78    = 32'sd313262;
    localparam t_q16 K18_33   = 32'sd1201275;
    localparam t_q16 K40_94   = 32'sd2683044;
    localparam t_q16 K36      = 32'sd2359296;
    localparam t_q16 LOSS_MIN = -32'sd16384;
    localparam t_q16 LOSS_MAX = 32'sd65535;
    localparam logic [14:0] LOG10_2 = 15'd19728;
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;  // 2^35 / 10, rounded up

    // Item context that travels beside the arithmetic.
    typedef struct packed {
        logic [2:0] model;
        logic [9:0] hm;
        logic       large_city;
        logic       low_band;    // carrier below 200 MHz
        logic [1:0] area;
    } t_side;

    typedef struct packed {
        logic [2:0]         model;
        logic signed [16:0] loss;
    } t_result;

    // log2(1 + idx / 2^bits) in Q16, truncated, by repeated squaring of a Q30 mantissa.
    function automatic logic [15:0] log_tab_entry(int unsigned idx, int unsigned bits);
        longint unsigned y;
        logic [15:0]     frac;
        y    = ((longint'(1) << bits) + longint'(idx)) << (30 - bits);
        frac = '0;
        for (int k = 0; k < 16; k++) begin
            y    = (y * y) >> 30;
            frac = {frac[14:0], 1'b0};
            if (y >= (longint'(2) << 30)) begin
                y       = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return frac;
    endfunction

    // log10(28) in Q16 as the table unit computes it.
    function automatic t_q16 lg10_28(int unsigned bits);
        longint unsigned l2;
        l2 = longint'(4) * 65536 + longint'(log_tab_entry(12 << (bits - 4), bits));
        return t_q16'((l2 * 19728) >> 16);
    endfunction

    // Q16 product scaled back, truncating toward zero.
    function automatic t_q16 q16_trunc(t_prod p);
        t_prod adj;
        adj = p + (p[P_W-1] ? t_prod'(65535) : t_prod'(0));
        return t_q16'(adj >>> 16);
    endfunction

endpackage

### hw/rtl/okumura_hata_path_loss_unit.sv
// Top level of the Okumura-Hata / COST-231 path loss unit: config registers,
// input stage, four log10 units, the evaluator pipeline and the output skid stage.
// Depends on ohpl_pkg, ohpl_log10, ohpl_calc and ohpl_skid.

// The unit takes one transaction per clock while its input ready is high: base and
// mobile antenna heights in decimeters and the link distance in meters, and returns
// the path loss in dB as a signed Q8 value with a code for the model that produced
// it. The carrier register picks the model: Okumura-Hata up to 1500 MHz, COST-231
// Hata up to 2170 MHz, the empirical 36 + 26 log10(d) rule up to 2690 MHz, and
// out of band above. Links at or below the minimum distance return zero loss. A
// transaction passes through 14 register stages: one input register, three in the
// table-driven log10 units (normalize, table read, scale), nine in the evaluator,
// and the output register that ends the path. Results leave in input order, one
// per cycle while the output is ready. The output stage has a skid entry, so new
// transactions are taken while a finished result waits; input ready drops only when
// that entry is occupied. Configuration is written through a plain write port and
// must only change while no transaction is in flight.
module okumura_hata_path_loss_unit
    import ohpl_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // base_height_dm [13:0], mobile_height_dm [23:14], distance_m [40:24], zero fill
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // loss_q8 [16:0] (signed), zero fill
    output logic [23:0] o_m_axis_tdata,
    // model_used [2:0]
    output logic [2:0]  o_m_axis_tuser
);
    logic [11:0] r_carrier;
    logic        r_large_city;
    logic [1:0]  r_area;
    logic [9:0]  r_min_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier    <= 12'd900;
            r_large_city <= 1'b1;
            r_area       <= 2'd0;
            r_min_dist   <= 10'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CARRIER:    r_carrier    <= i_cfg_wdata;
                CFG_LARGE_CITY: r_large_city <= i_cfg_wdata[0];
                CFG_AREA:       r_area       <= i_cfg_wdata[1:0];
                CFG_MIN_DIST:   r_min_dist   <= i_cfg_wdata[9:0];
                default:        ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the skid entry is free.
    logic en;
    logic w_accept;
    assign w_accept        = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    logic [13:0] w_hb;
    logic [9:0]  w_hm;
    logic [16:0] w_d;
    logic [11:0] w_f;
    logic        w_low;
    logic [2:0]  w_model;
    t_side       w_side;

    assign w_hb  = (i_s_axis_tdata[13:0] == '0) ? 14'd1 : i_s_axis_tdata[13:0];
    assign w_hm  = (i_s_axis_tdata[23:14] == '0) ? 10'd1 : i_s_axis_tdata[23:14];
    assign w_d   = i_s_axis_tdata[40:24];
    assign w_f   = (r_carrier == '0) ? 12'd1 : r_carrier;
    assign w_low = r_carrier < 12'd200;

    always_comb begin
        priority if (w_d <= 17'(r_min_dist)) begin
            w_model = MODEL_SHORT;
        end else if (r_carrier <= 12'd1500) begin
            w_model = MODEL_HATA;
        end else if (r_carrier <= 12'd2170) begin
            w_model = MODEL_COST;
        end else if (r_carrier <= 12'd2690) begin
            w_model = MODEL_EMP;
        end else begin
            w_model = MODEL_OOB;
        end
    end

    assign w_side = '{model: w_model, hm: w_hm, large_city: r_large_city,
                      low_band: w_low, area: r_area};

    // Input stage.
    logic           r_s0_v;
    t_side          r_s0_side;
    logic [L_W-1:0] r_s0_f, r_s0_hb, r_s0_d, r_s0_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side <= w_side;
            r_s0_f    <= L_W'(w_f);
            r_s0_hb   <= L_W'(w_hb);
            r_s0_d    <= L_W'(w_d);
            // 1.54 hm or 11.75 hm, both times 1000, as an integer.
            r_s0_k    <= L_W'(w_hm) * (w_low ? L_W'(154) : L_W'(1175));
        end
    end

    // Context follows the three log10 stages.
    logic  r_l1_v, r_l2_v, r_l3_v;
    t_side r_l1_side, r_l2_side, r_l3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_v <= 1'b0;
            r_l2_v <= 1'b0;
            r_l3_v <= 1'b0;
        end else if (en) begin
            r_l1_v <= r_s0_v;
            r_l2_v <= r_l1_v;
            r_l3_v <= r_l2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1_side <= r_s0_side;
            r_l2_side <= r_l1_side;
            r_l3_side <= r_l2_side;
        end
    end

    logic [LOUT_W-1:0] w_lf, w_lhb, w_ld, w_lt;

    ohpl_log10 #(.TAB_BITS(LOG_TABLE_BITS)) u_log_f (
        .i_clk(i_clk), .i_en(en), .i_value(r_s0_f), .o_log(w_lf));
    ohpl_log10 #(.TAB_BITS(LOG_TABLE_BITS)) u_log_hb (
        .i_clk(i_clk), .i_en(en), .i_value(r_s0_hb), .o_log(w_lhb));
    ohpl_log10 #(.TAB_BITS(LOG_TABLE_BITS)) u_log_d (
        .i_clk(i_clk), .i_en(en), .i_value(r_s0_d), .o_log(w_ld));
    ohpl_log10 #(.TAB_BITS(LOG_TABLE_BITS)) u_log_t (
        .i_clk(i_clk), .i_en(en), .i_value(r_s0_k), .o_log(w_lt));

    logic    w_calc_v;
    t_result w_calc_res, w_out;

    ohpl_calc #(.TAB_BITS(LOG_TABLE_BITS)) u_calc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_l3_v),
        .i_side(r_l3_side), .i_lf(w_lf), .i_lhb(w_lhb), .i_ld(w_ld), .i_lt(w_lt),
        .o_valid(w_calc_v), .o_result(w_calc_res));

    ohpl_skid u_skid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_calc_v), .o_ready(en),
        .i_data(w_calc_res), .o_valid(o_m_axis_tvalid), .i_ready(i_m_axis_tready),
        .o_data(w_out));

    assign o_m_axis_tdata = {7'b0, w_out.loss};
    assign o_m_axis_tuser = w_out.model;

    // The skid entry only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("skid entry occupied with no output pending");

    // Short links and out of band carriers always report zero loss.
    a_zero_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == MODEL_SHORT || o_m_axis_tuser == MODEL_OOB))
        |-> (o_m_axis_tdata == '0))
        else $error("nonzero loss for a short link or out of band carrier");

    // An accepted transaction reaches the input stage on the next enabled edge.
    a_entry_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept) |=> r_s0_v)
        else $error("accepted transaction lost at the input stage");
endmodule

### hw/rtl/ohpl_log10.sv
// Three-stage table-driven log10 unit: leading-one normalize, table read, scale.
// Depends on ohpl_pkg for widths and the table builder.
module ohpl_log10
    import ohpl_pkg::*;
#(
    parameter int TAB_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [L_W-1:0]    i_value,
    output logic [LOUT_W-1:0] o_log
);
    localparam int TAB_SIZE = 1 << TAB_BITS;
    localparam int E_W      = $clog2(L_W);

    logic [15:0]         w_tab [TAB_SIZE];
    logic [E_W-1:0]      w_e;
    logic [L_W-1:0]      w_norm;
    logic [E_W-1:0]      r_e1, r_e2;
    logic [TAB_BITS-1:0] r_idx;
    logic [15:0]         r_frac;
    logic [20:0]         w_l2;
    logic [35:0]         w_scaled;
    logic [LOUT_W-1:0]   r_log;

    for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
        localparam logic [15:0] ENTRY = log_tab_entry(g, TAB_BITS);
        assign w_tab[g] = ENTRY;
    end

    // Zero reads as one: exponent 0, fraction index 0.
    always_comb begin
        w_e = '0;
        for (int b = 1; b < L_W; b++) begin
            if (i_value[b]) w_e = E_W'(b);
        end
    end

    assign w_norm   = i_value << (E_W'(L_W - 1) - w_e);
    assign w_l2     = {r_e2, 16'h0000} + 21'(r_frac);
    assign w_scaled = 36'(w_l2) * 36'(LOG10_2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1   <= w_e;
            r_idx  <= w_norm[L_W-2 -: TAB_BITS];
            r_e2   <= r_e1;
            r_frac <= w_tab[r_idx];
            r_log  <= w_scaled[16 +: LOUT_W];
        end
    end

    assign o_log = r_log;
endmodule

### hw/rtl/ohpl_calc.sv
// Nine-stage fixed point evaluator that turns the four logarithms into a Q8 loss.
// Depends on ohpl_pkg for constants, the side record and the truncating scale helper.
module ohpl_calc
    import ohpl_pkg::*;
#(
    parameter int TAB_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [LOUT_W-1:0] i_lf,
    input  logic [LOUT_W-1:0] i_lhb,
    input  logic [LOUT_W-1:0] i_ld,
    input  logic [LOUT_W-1:0] i_lt,
    output logic              o_valid,
    output t_result           o_result
);
    localparam t_q16 LG28 = lg10_28(TAB_BITS);

    logic [9:1] r_v;
    t_side      r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;

    // Stage 1: remove decade offsets and the log10(28) offset, form the empirical loss.
    t_q16 r1_lf, r1_lhb, r1_ld, r1_t, r1_ts, r1_emp;
    // Stage 2: first products.
    t_prod r2_slope, r2_f, r2_hb, r2_tt, r2_a11, r2_a156, r2_lflf, r2_tsts, r2_1833;
    t_q16  r2_ld, r2_emp;
    // Stage 3: scaled products.
    t_q16 r3_slope, r3_f, r3_hb, r3_tt, r3_a11m, r3_a156m, r3_lflf, r3_tsts, r3_1833;
    t_q16 r3_ld, r3_emp;
    // Stage 4: second products.
    t_prod r4_sl, r4_ah, r4_hm, r4_478;
    t_q16  r4_f, r4_hb, r4_a156m, r4_tsts, r4_1833, r4_emp;
    // Stage 5.
    t_q16        r5_sl, r5_ah, r5_478, r5_f, r5_hb, r5_a156m, r5_tsts, r5_1833, r5_emp;
    logic [31:0] r5_mag;
    logic        r5_neg;
    // Stage 6.
    logic [63:0] r6_rec;
    logic        r6_neg;
    t_q16        r6_ahl, r6_area, r6_part, r6_a156m, r6_emp;
    // Stage 7.
    t_q16 r7_ahs, r7_ahl, r7_sum, r7_emp;
    // Stage 8.
    t_q16 r8_loss;
    // Stage 9.
    t_result r9_res;

    t_q16 w_area, w_div, w_q8;

    always_comb begin
        w_area = '0;
        if (r_s5.model == MODEL_HATA) begin
            if (r_s5.area == AREA_SUBURBAN) begin
                w_area = -((r5_tsts <<< 1) + K5_4);
            end else if (r_s5.area == AREA_OPEN) begin
                w_area = r5_1833 - r5_478 - K40_94;
            end
        end
    end

    assign w_div = t_q16'({3'b000, r6_rec[63:35]});
    assign w_q8  = (r8_loss + 32'sd128) >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[8:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= i_side; r_s2 <= r_s1; r_s3 <= r_s2; r_s4 <= r_s3;
            r_s5 <= r_s4;   r_s6 <= r_s5; r_s7 <= r_s6; r_s8 <= r_s7;

            r1_lf  <= t_q16'({12'h000, i_lf});
            r1_lhb <= t_q16'({12'h000, i_lhb}) - ONE_Q16;
            r1_ld  <= t_q16'({12'h000, i_ld}) - 3 * ONE_Q16;
            r1_t   <= t_q16'({12'h000, i_lt}) - 3 * ONE_Q16;
            r1_ts  <= t_q16'({12'h000, i_lf}) - LG28;
            r1_emp <= K36 + t_q16'(26) * t_q16'({12'h000, i_ld});

            r2_slope <= t_prod'(K6_55) * t_prod'(r1_lhb);
            r2_f     <= t_prod'((r_s1.model == MODEL_COST) ? K33_9 : K26_16) * t_prod'(r1_lf);
            r2_hb    <= t_prod'(K13_82) * t_prod'(r1_lhb);
            r2_tt    <= t_prod'(r1_t) * t_prod'(r1_t);
            r2_a11   <= t_prod'(K1_1) * t_prod'(r1_lf);
            r2_a156  <= t_prod'(K1_56) * t_prod'(r1_lf);
            r2_lflf  <= t_prod'(r1_lf) * t_prod'(r1_lf);
            r2_tsts  <= t_prod'(r1_ts) * t_prod'(r1_ts);
            r2_1833  <= t_prod'(K18_33) * t_prod'(r1_lf);
            r2_ld    <= r1_ld;
            r2_emp   <= r1_emp;

            r3_slope <= K44_9 - q16_trunc(r2_slope);
            r3_f     <= q16_trunc(r2_f);
            r3_hb    <= q16_trunc(r2_hb);
            r3_tt    <= q16_trunc(r2_tt);
            r3_a11m  <= q16_trunc(r2_a11) - K0_7;
            r3_a156m <= q16_trunc(r2_a156) - K0_8;
            r3_lflf  <= q16_trunc(r2_lflf);
            r3_tsts  <= q16_trunc(r2_tsts);
            r3_1833  <= q16_trunc(r2_1833);
            r3_ld    <= r2_ld;
            r3_emp   <= r2_emp;

            r4_sl    <= t_prod'(r3_slope) * t_prod'(r3_ld);
            r4_ah    <= t_prod'(r_s3.low_band ? K8_29 : K3_2) * t_prod'(r3_tt);
            r4_hm    <= t_prod'(r3_a11m) * t_prod'({1'b0, r_s3.hm});
            r4_478   <= t_prod'(K4_78) * t_prod'(r3_lflf);
            r4_f     <= r3_f;
            r4_hb    <= r3_hb;
            r4_a156m <= r3_a156m;
            r4_tsts  <= r3_tsts;
            r4_1833  <= r3_1833;
            r4_emp   <= r3_emp;

            r5_sl    <= q16_trunc(r4_sl);
            r5_ah    <= q16_trunc(r4_ah);
            r5_478   <= q16_trunc(r4_478);
            r5_neg   <= r4_hm[P_W-1];
            r5_mag   <= r4_hm[P_W-1] ? 32'(-r4_hm) : 32'(r4_hm);
            r5_f     <= r4_f;
            r5_hb    <= r4_hb;
            r5_a156m <= r4_a156m;
            r5_tsts  <= r4_tsts;
            r5_1833  <= r4_1833;
            r5_emp   <= r4_emp;

            // Small city term divides by ten through a reciprocal multiply.
            r6_rec   <= 64'(r5_mag) * 64'(RECIP10);
            r6_neg   <= r5_neg;
            r6_ahl   <= r5_ah - (r_s5.low_band ? K1_1 : K4_97);
            r6_area  <= w_area;
            r6_part  <= ((r_s5.model == MODEL_COST) ? K46_3 : K69_55) + r5_f - r5_hb + r5_sl;
            r6_a156m <= r5_a156m;
            r6_emp   <= r5_emp;

            r7_ahs <= (r6_neg ? -w_div : w_div) - r6_a156m;
            r7_ahl <= r6_ahl;
            r7_sum <= r6_part + r6_area;
            r7_emp <= r6_emp;

            if (r_s7.model == MODEL_EMP) begin
                r8_loss <= r7_emp;
            end else begin
                r8_loss <= r7_sum - (r_s7.large_city ? r7_ahl : r7_ahs);
            end

            r9_res.model <= r_s8.model;
            if (r_s8.model == MODEL_SHORT || r_s8.model == MODEL_OOB) begin
                r9_res.loss <= '0;
            end else if (w_q8 < LOSS_MIN) begin
                r9_res.loss <= LOSS_MIN[16:0];
            end else if (w_q8 > LOSS_MAX) begin
                r9_res.loss <= LOSS_MAX[16:0];
            end else begin
                r9_res.loss <= w_q8[16:0];
            end
        end
    end

    assign o_valid  = r_v[9];
    assign o_result = r9_res;
endmodule

### hw/rtl/ohpl_skid.sv
// Output register with one skid entry, so the pipeline keeps moving while a result waits.
// Depends on ohpl_pkg for the result record.
module ohpl_skid
    import ohpl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);
    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (r_out_v && !i_ready) begin
            if (i_valid) begin
                r_skid   <= i_data;
                r_skid_v <= 1'b1;
            end
        end else begin
            r_out   <= i_data;
            r_out_v <= i_valid;
        end
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;
endmodule

### tb/tb_okumura_hata_path_loss_unit.sv
// Self-checking testbench for okumura_hata_path_loss_unit.
// Holds a fixed point predictor of the path loss and drives random streams with stalls.
// Depends on ohpl_pkg and the okumura_hata_path_loss_unit RTL.
`timescale 1ns / 100ps

module tb_okumura_hata_path_loss_unit;
    import ohpl_pkg::*;

    localparam int TAB_BITS   = 10;
    localparam int DRAIN_WAIT = 24;    // a little above the 14 stage pipeline
    localparam int HANG_LIMIT = 4000;  // cycles without any transaction

    typedef struct {
        logic [16:0] loss;
        logic [2:0]  model;
    } t_loss_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [11:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // base_height_dm [13:0], mobile_height_dm [23:14], distance_m [40:24], zero fill
    logic [47:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // loss_q8 [16:0] (signed), zero fill
    logic [23:0] o_m_axis_tdata;
    // model_used [2:0]
    logic [2:0]  o_m_axis_tuser;

    okumura_hata_path_loss_unit #(.LOG_TABLE_BITS(TAB_BITS)) dut (.*);

    always #10 i_clk = ~i_clk;

    // Local copy of the configuration, mirrored on every register write.
    int unsigned carrier = 900;
    bit          big_city = 1'b1;
    int unsigned area = 0;
    int unsigned min_dist = 1;

    longint unsigned log2_frac [1 << TAB_BITS];
    t_loss_exp       loss_q[$];
    int              errors = 0;
    bit              steady = 1'b0;  // when set, neither side idles
    int              quiet_cycles = 0;

    // Fractional log2 table: log2(1 + i/2^bits) in Q16 by squaring a Q30 mantissa.
    function automatic void build_log_table();
        longint unsigned y;
        longint unsigned frac;
        for (int i = 0; i < (1 << TAB_BITS); i++) begin
            y    = ((longint'(1) << TAB_BITS) + i) << (30 - TAB_BITS);
            frac = 0;
            for (int k = 0; k < 16; k++) begin
                y    = (y * y) >> 30;
                frac = frac << 1;
                if (y >= (longint'(2) << 30)) begin
                    y    = y >> 1;
                    frac = frac | 1;
                end
            end
            log2_frac[i] = frac;
        end
    endfunction

    // Table driven log10 in Q16; zero counts as one.
    function automatic longint log10_q16(longint v);
        longint mask;
        longint idx;
        longint l2;
        int     e;
        mask = (longint'(1) << TAB_BITS) - 1;
        e    = 0;
        if (v == 0) v = 1;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        if (e >= TAB_BITS) idx = (v >> (e - TAB_BITS)) & mask;
        else               idx = (v << (TAB_BITS - e)) & mask;
        l2 = longint'(e) * 65536 + longint'(log2_frac[idx]);
        return (l2 * 19728) >>> 16;
    endfunction

    // Q16 product, truncated toward zero.
    function automatic longint mul_q16(longint a, longint b);
        return (a * b) / 65536;
    endfunction

    // Computes the loss and model code for one link under the current settings.
    function automatic t_loss_exp path_loss(longint hb, longint hm, longint d);
        t_loss_exp r;
        longint    lf, lhb, ld, slope, ah, t, loss, v, q;
        logic [2:0] model;
        loss = 0;
        if (hb == 0) hb = 1;
        if (hm == 0) hm = 1;
        if (d <= min_dist) begin
            model = MODEL_SHORT;
        end else if (carrier <= 2170) begin
            lf    = log10_q16(carrier);
            lhb   = log10_q16(hb) - ONE_Q16;
            ld    = log10_q16(d) - 3 * ONE_Q16;
            slope = K44_9 - mul_q16(K6_55, lhb);
            if (big_city) begin
                if (carrier < 200) begin
                    t  = log10_q16(154 * hm) - 3 * ONE_Q16;
                    ah = mul_q16(K8_29, mul_q16(t, t)) - K1_1;
                end else begin
                    t  = log10_q16(1175 * hm) - 3 * ONE_Q16;
                    ah = mul_q16(K3_2, mul_q16(t, t)) - K4_97;
                end
            end else begin
                ah = ((mul_q16(K1_1, lf) - K0_7) * hm) / 10 - (mul_q16(K1_56, lf) - K0_8);
            end
            if (carrier <= 1500) begin
                model = MODEL_HATA;
                loss  = K69_55 + mul_q16(K26_16, lf) - mul_q16(K13_82, lhb) - ah
                        + mul_q16(slope, ld);
                if (area == AREA_SUBURBAN) begin
                    t    = lf - log10_q16(28);
                    loss = loss - (2 * mul_q16(t, t) + K5_4);
                end else if (area == AREA_OPEN) begin
                    loss = loss - mul_q16(K4_78, mul_q16(lf, lf)) + mul_q16(K18_33, lf)
                           - K40_94;
                end
            end else begin
                model = MODEL_COST;
                loss  = K46_3 + mul_q16(K33_9, lf) - mul_q16(K13_82, lhb) - ah
                        + mul_q16(slope, ld);
            end
        end else if (carrier <= 2690) begin
            model = MODEL_EMP;
            loss  = K36 + 26 * log10_q16(d);
        end else begin
            model = MODEL_OOB;
        end
        // Round to Q8 toward minus infinity after adding half, then clamp.
        v = loss + 128;
        q = (v >= 0) ? v / 256 : -((-v + 255) / 256);
        if (q < LOSS_MIN) q = LOSS_MIN;
        if (q > LOSS_MAX) q = LOSS_MAX;
        r.model = model;
        r.loss  = (model == MODEL_SHORT || model == MODEL_OOB) ? 17'd0 : q[16:0];
        return r;
    endfunction

    // Random idle length: mostly short, now and then long.
    function automatic int idle_len();
        if (steady) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 25);
    endfunction

    // Sends one link transaction; the expectation is queued once the handshake is certain.
    task automatic send_link(int unsigned hb, int unsigned hm, int unsigned d);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, d[16:0], hm[9:0], hb[13:0]};
        // Outputs change only at rising edges, so the falling edge shows
        // whether the next rising edge completes the transaction.
        do @(negedge i_clk); while (!o_s_axis_tready);
        loss_q.push_back(path_loss(hb[13:0], hm[9:0], d[16:0]));
        @(posedge i_clk);
    endtask

    // Waits until every expected result has arrived plus the pipeline depth.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (loss_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[11:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CARRIER:    carrier  = val & 12'hFFF;
            CFG_LARGE_CITY: big_city = val[0];
            CFG_AREA:       area     = val & 2'h3;
            CFG_MIN_DIST:   min_dist = val & 10'h3FF;
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned f, int unsigned lc, int unsigned ak, int unsigned md);
        write_reg(CFG_CARRIER, f);
        write_reg(CFG_LARGE_CITY, lc);
        write_reg(CFG_AREA, ak);
        write_reg(CFG_MIN_DIST, md);
    endtask

    // Field extremes under the reset settings, then the band edges, the
    // short link rule, the zero operands and both saturation limits.
    task automatic test_directed();
        steady = 1'b1;
        send_link(1, 1, 2);
        send_link(10000, 1000, 100000);
        send_link(16383, 1023, 131071);
        send_link(0, 0, 1000);
        send_link(500, 15, 0);
        send_link(500, 15, 1);
        drain();
        // Low band, large city with the huge base mast: clamps at the low limit.
        set_config(0, 1, 0, 1);
        send_link(16383, 1023, 2);
        send_link(0, 0, 5000);
        drain();
        // Long link from a tiny mast: clamps at the high limit.
        set_config(1500, 0, 3, 0);
        send_link(1, 1, 131071);
        send_link(300, 15, 1);
        drain();
        set_config(1501, 1, 1, 1023);
        send_link(300, 15, 1023);
        send_link(300, 15, 1024);
        drain();
        set_config(2690, 0, 2, 0);
        send_link(300, 15, 1);
        send_link(300, 15, 131071);
        drain();
        set_config(4095, 1, 2, 50);
        send_link(300, 15, 50);
        send_link(300, 15, 51);
        drain();
        set_config(199, 0, 1, 3);
        send_link(16383, 1023, 4);
        send_link(200, 20, 70000);
        drain();
        steady = 1'b0;
    endtask

    // Phases of random links, each under its own random settings.
    task automatic test_random();
        int unsigned edges [14] = '{0, 150, 199, 200, 900, 1500, 1501, 1800, 2170, 2171,
                                    2690, 2691, 4000, 4095};
        int unsigned f, md, hb, hm, d;
        for (int ph = 0; ph < 20; ph++) begin
            f  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095)
                                             : edges[$urandom_range(0, 13)];
            md = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 20);
            set_config(f, $urandom_range(0, 1), $urandom_range(0, 3), md);
            steady = (ph % 5 == 4);
            for (int n = 0; n < 100; n++) begin
                hb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                 : $urandom_range(1, 10000);
                hm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(1, 1000);
                case ($urandom_range(0, 9))
                    0:       d = $urandom_range(0, md + 2);
                    1:       d = $urandom_range(0, 131071);
                    default: d = $urandom_range(0, 131071) >> $urandom_range(0, 12);
                endcase
                send_link(hb, hm, d);
            end
            drain();
        end
        steady = 1'b0;
    endtask

    // Receiver: ready drops for random stretches, mostly short.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (steady) begin
            i_m_axis_tready <= 1'b1;
            stall_left      <= 0;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                          : $urandom_range(5, 30);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Result checker: sampled at the falling edge, where all signals are settled.
    t_loss_exp want;
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (loss_q.size() == 0) begin
                $display("%0t: unexpected result loss %0d model %0d", $time,
                         $signed(o_m_axis_tdata[16:0]), o_m_axis_tuser);
                errors++;
            end else begin
                want = loss_q.pop_front();
                if (o_m_axis_tdata !== {7'd0, want.loss}) begin
                    $display("%0t: loss mismatch, expected %0d, got %0d (tdata %h)", $time,
                             $signed(want.loss), $signed(o_m_axis_tdata[16:0]),
                             o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tuser !== want.model) begin
                    $display("%0t: model mismatch, expected %0d, got %0d", $time,
                             want.model, o_m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transaction means a hang.
    always @(negedge i_clk) begin
        if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > HANG_LIMIT) begin
            $display("tb_okumura_hata_path_loss_unit failed");
            $finish;
        end
    end

    initial begin
        build_log_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain();
        if (errors == 0) begin
            $display("tb_okumura_hata_path_loss_unit passed");
        end else begin
            $display("tb_okumura_hata_path_loss_unit failed");
        end
        $finish;
    end

endmodule
